[src/mlfq_pkg.sv]
package mlfq_pkg;

	// Request opcodes.
	localparam logic [2:0] OP_ENQUEUE = 3'd0;
	localparam logic [2:0] OP_DEQUEUE = 3'd1;
	localparam logic [2:0] OP_PICK    = 3'd2;
	localparam logic [2:0] OP_CHARGE  = 3'd3;
	localparam logic [2:0] OP_BOOST   = 3'd4;
	localparam logic [2:0] OP_RETIRE  = 3'd5;

	// Enqueue reasons; codes above the signal reason behave as a start.
	localparam logic [2:0] RSN_YIELD  = 3'd0;
	localparam logic [2:0] RSN_WAKE   = 3'd1;
	localparam logic [2:0] RSN_SIGNAL = 3'd3;

	// Configuration register indexes.
	localparam logic [2:0] CFG_QUANTUM0      = 3'd0;
	localparam logic [2:0] CFG_QUANTUM1      = 3'd1;
	localparam logic [2:0] CFG_QUANTUM2      = 3'd2;
	localparam logic [2:0] CFG_QUANTUM3      = 3'd3;
	localparam logic [2:0] CFG_QUANTUM4      = 3'd4;
	localparam logic [2:0] CFG_BOOST_PERIOD  = 3'd5;
	localparam logic [2:0] CFG_PROMOTE_SLEEP = 3'd6;

	localparam int QUANTUM_REGS = 5;

	typedef enum logic [1:0] {
		SLOT_INACTIVE = 2'd0,
		SLOT_RUNNABLE = 2'd1,
		SLOT_RUNNING  = 2'd2,
		SLOT_SLEEPING = 2'd3
	} slot_status_t;

	typedef struct packed {
		slot_status_t status;
		logic [2:0]   level;
		logic [15:0]  budget;
		logic         expired;
	} slot_attr_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_READ,
		S_EXEC,
		S_UNL_PREV,
		S_UNL_NEXT,
		S_UNL_SELF,
		S_APP_SELF,
		S_APP_TAIL,
		S_NEXT,
		S_DONE
	} fsm_state_t;

endpackage

[src/mlfq_attr_mem.sv]
module mlfq_attr_mem
	import mlfq_pkg::*;
#(
	parameter int SLOTS = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(SLOTS)-1:0] waddr,
	input  slot_attr_t               wdata,
	input  logic [$clog2(SLOTS)-1:0] raddr,
	output slot_attr_t               rdata
);

	slot_attr_t mem [SLOTS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

[src/mlfq_link_mem.sv]
module mlfq_link_mem #(
	parameter int SLOTS = 64
) (
	input  logic                       clk,
	input  logic                       we_next,
	input  logic                       we_prev,
	input  logic [$clog2(SLOTS)-1:0]   waddr,
	input  logic [$clog2(SLOTS+1)-1:0] wnext,
	input  logic [$clog2(SLOTS+1)-1:0] wprev,
	input  logic [$clog2(SLOTS)-1:0]   raddr,
	output logic [$clog2(SLOTS+1)-1:0] rnext,
	output logic [$clog2(SLOTS+1)-1:0] rprev
);

	localparam int LW = $clog2(SLOTS + 1);

	// Each half of an entry has its own write enable.
	logic [LW-1:0] next_mem [SLOTS];
	logic [LW-1:0] prev_mem [SLOTS];

	always_ff @(posedge clk) begin
		if (we_next) begin
			next_mem[waddr] <= wnext;
		end
		if (we_prev) begin
			prev_mem[waddr] <= wprev;
		end
	end

	always_ff @(posedge clk) begin
		rnext <= next_mem[raddr];
		rprev <= prev_mem[raddr];
	end

endmodule

[src/mlfq_scheduler_core.sv]
// A boost check that fires walks every slot in turn. Throughput: one request at
// a time, the next is accepted once the current one has handed its result to the
// output register; the slot memories' single write ports set this.
// Reset: arst_n clears control state, then a clearing pass writes every memory
// entry to its reset value while requests are stalled.
module mlfq_scheduler_core
	import mlfq_pkg::*;
#(
	parameter int SLOTS  = 64,
	parameter int LEVELS = 5
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [19:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  opcode,
	input  logic [5:0]  slot,
	input  logic [2:0]  enqueue_reason,
	input  logic [31:0] now_tick,
	input  logic [31:0] block_tick,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        picked_valid,
	output logic [5:0]  picked_slot,
	output logic [2:0]  slot_level,
	output logic [15:0] slot_budget,
	output logic        slot_expired,
	output logic        boost_done
);

	// The per-slot state lives in two memories, each with one read and one write
	// port: attributes (status, level, budget, expired) and the queue links. Each
	// level's queue is a doubly linked list whose head and tail are kept in
	// flip-flops. A link value of SLOTS means no neighbor. Every request is a
	// registered read, then a read-modify-write sequence; all writes of one request
	// finish before the next read is issued, so no forwarding is needed.
	localparam int AW  = $clog2(SLOTS);
	localparam int LW  = $clog2(SLOTS + 1);
	localparam int LIW = $clog2(LEVELS);
	localparam logic [LW-1:0] NULL_LINK = LW'(SLOTS);

	fsm_state_t state_q, state_d;

	// Configuration registers.
	logic [15:0] quantum_q [QUANTUM_REGS];
	logic [19:0] boost_period_q;
	logic [15:0] promote_sleep_q;

	// Request context.
	logic [2:0]    op_q;
	logic [2:0]    reason_q;
	logic          slept_ok_q;
	logic [AW-1:0] cur_q;
	logic [AW-1:0] clr_q;
	logic [LIW-1:0] old_lv_q;
	logic [LW-1:0] pv_q, nx_q;
	slot_attr_t    new_q;
	logic          append_q;
	logic          report_q, picked_q, boosted_q;

	logic [LW-1:0] head_q [LEVELS];
	logic [LW-1:0] tail_q [LEVELS];
	logic [31:0]   last_boost_q;

	// Memory ports.
	slot_attr_t    attr_rd, attr_wd;
	logic          attr_we;
	logic [AW-1:0] attr_wa;
	logic [LW-1:0] link_rnext, link_rprev, link_wnext, link_wprev;
	logic          link_we_next, link_we_prev;
	logic [AW-1:0] link_wa;

	// Output register.
	logic        out_valid_q;
	logic        picked_valid_q;
	logic [5:0]  picked_slot_q;
	logic [2:0]  slot_level_q;
	logic [15:0] slot_budget_q;
	logic        slot_expired_q;
	logic        boost_done_q;

	function automatic logic [2:0] clamp_level(input logic [2:0] lv);
		return (lv >= 3'(LEVELS)) ? 3'(LEVELS - 1) : lv;
	endfunction

	logic        accept;
	logic        slot_in_range;
	logic        boost_due;
	logic        pick_found;
	logic [LIW-1:0] pick_lv;
	logic        out_free;

	assign accept        = in_valid && !in_stall;
	assign in_stall      = (state_q != S_IDLE);
	assign slot_in_range = (32'(slot) < SLOTS);
	assign boost_due     = ((now_tick - last_boost_q) >= 32'(boost_period_q));
	assign out_free      = !out_valid_q || !out_stall;

	// Lowest-numbered non-empty level, the one picked first.
	always_comb begin
		pick_found = 1'b0;
		pick_lv    = '0;
		for (int i = LEVELS - 1; i >= 0; i--) begin
			if (head_q[i] != NULL_LINK) begin
				pick_found = 1'b1;
				pick_lv    = LIW'(i);
			end
		end
	end

	mlfq_attr_mem #(.SLOTS(SLOTS)) u_attr_mem (
		.clk   (clk),
		.we    (attr_we),
		.waddr (attr_wa),
		.wdata (attr_wd),
		.raddr (cur_q),
		.rdata (attr_rd)
	);

	mlfq_link_mem #(.SLOTS(SLOTS)) u_link_mem (
		.clk     (clk),
		.we_next (link_we_next),
		.we_prev (link_we_prev),
		.waddr   (link_wa),
		.wnext   (link_wnext),
		.wprev   (link_wprev),
		.raddr   (cur_q),
		.rnext   (link_rnext),
		.rprev   (link_rprev)
	);

	// Per-opcode update of the slot that was just read.
	slot_attr_t ex_attr;
	logic       ex_write, ex_unlink, ex_append;
	logic [2:0] ex_olv, ex_nlv;
	logic       ex_yield, ex_promote;

	always_comb begin
		ex_attr    = attr_rd;
		ex_write   = 1'b0;
		ex_unlink  = 1'b0;
		ex_append  = 1'b0;
		ex_olv     = clamp_level(attr_rd.level);
		ex_nlv     = ex_olv;
		ex_yield   = (reason_q == RSN_YIELD);
		ex_promote = (reason_q >= RSN_WAKE) && (reason_q <= RSN_SIGNAL) && slept_ok_q;
		case (op_q)
			OP_ENQUEUE: begin
				// Expired yield demotes, a long enough sleep promotes.
				if (attr_rd.expired && ex_yield && (ex_olv < 3'(LEVELS - 1))) begin
					ex_nlv = ex_olv + 3'd1;
				end
				if (ex_promote && (ex_nlv != 3'd0)) begin
					ex_nlv = ex_nlv - 3'd1;
				end
				ex_attr.level   = ex_nlv;
				ex_attr.expired = 1'b0;
				ex_attr.status  = SLOT_RUNNABLE;
				if ((ex_nlv != ex_olv) || attr_rd.expired || !ex_yield) begin
					ex_attr.budget = quantum_q[clamp_level(ex_nlv)];
				end
				ex_write  = 1'b1;
				ex_unlink = (attr_rd.status == SLOT_RUNNABLE);
				ex_append = 1'b1;
			end
			OP_DEQUEUE: begin
				if (attr_rd.status != SLOT_INACTIVE) begin
					ex_attr.status = SLOT_SLEEPING;
				end
				ex_write  = 1'b1;
				ex_unlink = (attr_rd.status == SLOT_RUNNABLE);
			end
			OP_PICK: begin
				ex_attr.status = SLOT_RUNNING;
				ex_write       = 1'b1;
				ex_unlink      = 1'b1;
			end
			OP_CHARGE: begin
				if (attr_rd.budget > 16'd1) begin
					ex_attr.budget = attr_rd.budget - 16'd1;
				end else begin
					ex_attr.budget  = '0;
					ex_attr.expired = 1'b1;
				end
				ex_write = 1'b1;
			end
			OP_BOOST: begin
				// Only idle slots below level 1 move up; running ones stay put.
				if ((attr_rd.status == SLOT_RUNNABLE || attr_rd.status == SLOT_SLEEPING)
						&& (attr_rd.level > 3'd1)) begin
					ex_attr.level   = 3'd1;
					ex_attr.expired = 1'b0;
					ex_write        = 1'b1;
					if (attr_rd.status == SLOT_RUNNABLE) begin
						ex_attr.budget = quantum_q[clamp_level(3'd1)];
						ex_unlink      = 1'b1;
						ex_append      = 1'b1;
					end
				end
			end
			OP_RETIRE: begin
				ex_attr   = '0;
				ex_write  = 1'b1;
				ex_unlink = (attr_rd.status == SLOT_RUNNABLE);
			end
			default: begin
				ex_write = 1'b0;
			end
		endcase
	end

	logic [LIW-1:0] app_lv;
	fsm_state_t     finish_state;

	assign app_lv       = new_q.level[LIW-1:0];
	assign finish_state = (op_q == OP_BOOST) ? S_NEXT : S_DONE;

	// Next state and memory write controls.
	always_comb begin
		state_d      = state_q;
		attr_we      = 1'b0;
		attr_wa      = cur_q;
		attr_wd      = ex_attr;
		link_we_next = 1'b0;
		link_we_prev = 1'b0;
		link_wa      = cur_q;
		link_wnext   = NULL_LINK;
		link_wprev   = NULL_LINK;
		unique case (state_q)
			S_CLEAR: begin
				attr_we      = 1'b1;
				attr_wa      = clr_q;
				attr_wd      = '0;
				link_we_next = 1'b1;
				link_we_prev = 1'b1;
				link_wa      = clr_q;
				if (clr_q == AW'(SLOTS - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (accept) begin
					if (opcode == OP_PICK) begin
						state_d = pick_found ? S_READ : S_DONE;
					end else if (opcode == OP_BOOST) begin
						state_d = boost_due ? S_READ : S_DONE;
					end else if (opcode <= OP_RETIRE && slot_in_range) begin
						state_d = S_READ;
					end else begin
						state_d = S_DONE;
					end
				end
			end
			S_READ: begin
				state_d = S_EXEC;
			end
			S_EXEC: begin
				attr_we = ex_write;
				if (ex_unlink) begin
					state_d = S_UNL_PREV;
				end else if (ex_append) begin
					state_d = S_APP_SELF;
				end else begin
					state_d = finish_state;
				end
			end
			S_UNL_PREV: begin
				link_we_next = (pv_q != NULL_LINK);
				link_wa      = pv_q[AW-1:0];
				link_wnext   = nx_q;
				state_d      = S_UNL_NEXT;
			end
			S_UNL_NEXT: begin
				link_we_prev = (nx_q != NULL_LINK);
				link_wa      = nx_q[AW-1:0];
				link_wprev   = pv_q;
				state_d      = S_UNL_SELF;
			end
			S_UNL_SELF: begin
				link_we_next = 1'b1;
				link_we_prev = 1'b1;
				state_d      = append_q ? S_APP_SELF : finish_state;
			end
			S_APP_SELF: begin
				link_we_next = 1'b1;
				link_we_prev = 1'b1;
				link_wprev   = tail_q[app_lv];
				state_d      = S_APP_TAIL;
			end
			S_APP_TAIL: begin
				link_we_next = (tail_q[app_lv] != NULL_LINK);
				link_wa      = tail_q[app_lv][AW-1:0];
				link_wnext   = LW'(cur_q);
				state_d      = finish_state;
			end
			S_NEXT: begin
				state_d = (cur_q == AW'(SLOTS - 1)) ? S_DONE : S_READ;
			end
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Configuration port; writes land whatever the sequencer is doing.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quantum_q[0]    <= 16'd2;
			quantum_q[1]    <= 16'd4;
			quantum_q[2]    <= 16'd8;
			quantum_q[3]    <= 16'd16;
			quantum_q[4]    <= 16'd32;
			boost_period_q  <= 20'd100;
			promote_sleep_q <= 16'd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_QUANTUM0:      quantum_q[0]    <= cfg_data[15:0];
				CFG_QUANTUM1:      quantum_q[1]    <= cfg_data[15:0];
				CFG_QUANTUM2:      quantum_q[2]    <= cfg_data[15:0];
				CFG_QUANTUM3:      quantum_q[3]    <= cfg_data[15:0];
				CFG_QUANTUM4:      quantum_q[4]    <= cfg_data[15:0];
				CFG_BOOST_PERIOD:  boost_period_q  <= cfg_data;
				CFG_PROMOTE_SLEEP: promote_sleep_q <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	// Request context, queue heads and tails, boost timestamp.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q        <= '0;
			cur_q        <= '0;
			op_q         <= OP_ENQUEUE;
			reason_q     <= RSN_YIELD;
			slept_ok_q   <= 1'b0;
			old_lv_q     <= '0;
			pv_q         <= NULL_LINK;
			nx_q         <= NULL_LINK;
			new_q        <= '0;
			append_q     <= 1'b0;
			report_q     <= 1'b0;
			picked_q     <= 1'b0;
			boosted_q    <= 1'b0;
			last_boost_q <= '0;
			for (int i = 0; i < LEVELS; i++) begin
				head_q[i] <= NULL_LINK;
				tail_q[i] <= NULL_LINK;
			end
		end else begin
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
				end
				S_IDLE: begin
					if (accept) begin
						op_q       <= opcode;
						reason_q   <= enqueue_reason;
						slept_ok_q <= ((now_tick - block_tick) >= 32'(promote_sleep_q));
						if (opcode == OP_PICK) begin
							cur_q     <= head_q[pick_lv][AW-1:0];
							picked_q  <= pick_found;
							report_q  <= pick_found;
							boosted_q <= 1'b0;
						end else if (opcode == OP_BOOST) begin
							cur_q     <= '0;
							picked_q  <= 1'b0;
							report_q  <= 1'b0;
							boosted_q <= boost_due;
							if (boost_due) begin
								last_boost_q <= now_tick;
							end
						end else begin
							cur_q     <= AW'(slot);
							picked_q  <= 1'b0;
							boosted_q <= 1'b0;
							report_q  <= (opcode <= OP_RETIRE) && slot_in_range;
						end
					end
				end
				S_EXEC: begin
					old_lv_q <= ex_olv[LIW-1:0];
					pv_q     <= link_rprev;
					nx_q     <= link_rnext;
					new_q    <= ex_attr;
					append_q <= ex_append;
				end
				S_UNL_PREV: begin
					if (pv_q == NULL_LINK) begin
						head_q[old_lv_q] <= nx_q;
					end
				end
				S_UNL_NEXT: begin
					if (nx_q == NULL_LINK) begin
						tail_q[old_lv_q] <= pv_q;
					end
				end
				S_APP_TAIL: begin
					if (tail_q[app_lv] == NULL_LINK) begin
						head_q[app_lv] <= LW'(cur_q);
					end
					tail_q[app_lv] <= LW'(cur_q);
				end
				S_NEXT: begin
					cur_q <= cur_q + AW'(1);
				end
				default: begin
				end
			endcase
		end
	end

	// Output register: parts the sequencer from the consumer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			picked_valid_q <= picked_q;
			picked_slot_q  <= picked_q ? 6'(cur_q) : 6'd0;
			slot_level_q   <= report_q ? new_q.level : 3'd0;
			slot_budget_q  <= report_q ? new_q.budget : 16'd0;
			slot_expired_q <= report_q ? new_q.expired : 1'b0;
			boost_done_q   <= boosted_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign picked_valid = picked_valid_q;
	assign picked_slot  = picked_slot_q;
	assign slot_level   = slot_level_q;
	assign slot_budget  = slot_budget_q;
	assign slot_expired = slot_expired_q;
	assign boost_done   = boost_done_q;

	// Between requests a level's head and tail are either both empty or both set.
	for (genvar g = 0; g < LEVELS; g++) begin : g_queue_check
		a_head_tail: assert property (@(posedge clk) disable iff (!arst_n)
			(state_q == S_IDLE) |->
				((head_q[g] == NULL_LINK) == (tail_q[g] == NULL_LINK)))
			else $error("level queue head and tail disagree on emptiness");
	end

	// A result never reports both a pick and a boost.
	a_pick_boost: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(picked_valid && boost_done))
		else $error("pick and boost reported together");

	// A picked slot always reports a level inside the queue range.
	a_pick_level: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && picked_valid) |-> (32'(slot_level) < LEVELS))
		else $error("picked slot reports a level out of range");

	// Link writes address real slots only.
	a_link_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(link_we_next || link_we_prev) |-> (32'(link_wa) < SLOTS))
		else $error("link memory written at a null address");

endmodule

[tb/sv/mlfq_scheduler_core_tb.sv]
`timescale 1ns / 100ps

module mlfq_scheduler_core_tb
	import mlfq_pkg::*;
();

	localparam int NSLOT = 64;
	localparam int NLVL = 5;
	localparam int NIL = NSLOT;
	// A firing boost walks every slot.
	localparam int SETTLE_CYCLES = 700;

	// One result as the scheduler reports it.
	typedef struct {
		bit        pv;
		bit [5:0]  ps;
		bit [2:0]  lvl;
		bit [15:0] bud;
		bit        exp;
		bit        boosted;
	} sched_result_t;

	// Scheduler mirror: it keeps its own copy of the slot table, the level lists and
	// the registers, works out the result of every accepted request and checks the
	// block's results against them in order.
	class sched_scoreboard;
		bit [2:0]     lvl_q[NSLOT];
		bit [15:0]    bud_q[NSLOT];
		bit           exp_q[NSLOT];
		slot_status_t st_q[NSLOT];
		int           nxt[NSLOT];
		int           prv[NSLOT];
		int           head[NLVL];
		int           tail[NLVL];
		bit [31:0]    last_boost;
		bit [15:0]    quantum[QUANTUM_REGS];
		bit [19:0]    boost_period;
		bit [15:0]    promote_sleep;
		sched_result_t pending_q[$];
		int           errors;

		function void reset_state();
			for (int i = 0; i < NSLOT; i++) begin
				lvl_q[i] = 0; bud_q[i] = 0; exp_q[i] = 0; st_q[i] = SLOT_INACTIVE;
				nxt[i] = NIL; prv[i] = NIL;
			end
			for (int i = 0; i < NLVL; i++) begin
				head[i] = NIL; tail[i] = NIL;
			end
			last_boost = 0;
			quantum = '{16'd2, 16'd4, 16'd8, 16'd16, 16'd32};
			boost_period = 100;
			promote_sleep = 1;
			errors = 0;
		endfunction

		function void write_reg(bit [2:0] idx, bit [19:0] val);
			if (idx <= CFG_QUANTUM4)
				quantum[idx] = val[15:0];
			else if (idx == CFG_BOOST_PERIOD)
				boost_period = val;
			else if (idx == CFG_PROMOTE_SLEEP)
				promote_sleep = val[15:0];
		endfunction

		function void unlink(int s);
			int l, p, n;
			l = (lvl_q[s] >= NLVL) ? NLVL - 1 : lvl_q[s];
			p = prv[s];
			n = nxt[s];
			if (p < NIL) nxt[p] = n; else head[l] = n;
			if (n < NIL) prv[n] = p; else tail[l] = p;
			nxt[s] = NIL;
			prv[s] = NIL;
		endfunction

		function void append(int l, int s);
			int t;
			t = tail[l];
			nxt[s] = NIL;
			prv[s] = t;
			if (t < NIL) nxt[t] = s; else head[l] = s;
			tail[l] = s;
		endfunction

		function void enqueue(int s, bit [2:0] reason, bit [31:0] now, bit [31:0] blk);
			int orig, l;
			bit was_exp, yield;
			bit [31:0] slept;
			yield = (reason == RSN_YIELD);
			if (st_q[s] == SLOT_RUNNABLE) unlink(s);
			orig = (lvl_q[s] >= NLVL) ? NLVL - 1 : lvl_q[s];
			l = orig;
			was_exp = exp_q[s];
			// An expired budget on a yield costs one level; the bottom level holds.
			if (was_exp && yield && l < NLVL - 1) l++;
			exp_q[s] = 0;
			// Waking after a long enough sleep earns one level back.
			if (reason >= RSN_WAKE && reason <= RSN_SIGNAL) begin
				slept = now - blk;
				if (slept >= promote_sleep && l > 0) l--;
			end
			lvl_q[s] = 3'(l);
			if (l != orig || was_exp || !yield) bud_q[s] = quantum[l];
			st_q[s] = SLOT_RUNNABLE;
			append(l, s);
		endfunction

		// Notes an accepted request and queues the result it must produce.
		function void note_request(bit [2:0] op, bit [5:0] s, bit [2:0] reason,
				bit [31:0] now, bit [31:0] blk);
			sched_result_t r;
			bit report;
			int rs;
			r = '{default: 0};
			report = 0;
			rs = 0;
			if (op == OP_PICK) begin
				for (int l = 0; l < NLVL; l++) begin
					if (head[l] < NIL) begin
						rs = head[l];
						unlink(rs);
						st_q[rs] = SLOT_RUNNING;
						r.pv = 1;
						r.ps = 6'(rs);
						report = 1;
						break;
					end
				end
			end else if (op == OP_BOOST) begin
				if (now - last_boost >= boost_period) begin
					last_boost = now;
					for (int i = 0; i < NSLOT; i++) begin
						if (st_q[i] == SLOT_INACTIVE || st_q[i] == SLOT_RUNNING || lvl_q[i] <= 1)
							continue;
						if (st_q[i] == SLOT_RUNNABLE) begin
							unlink(i);
							lvl_q[i] = 1;
							bud_q[i] = quantum[1];
							exp_q[i] = 0;
							append(1, i);
						end else begin
							lvl_q[i] = 1;
							exp_q[i] = 0;
						end
					end
					r.boosted = 1;
				end
			end else if (op <= OP_RETIRE) begin
				report = 1;
				rs = s;
				case (op)
					OP_ENQUEUE: enqueue(s, reason, now, blk);
					OP_DEQUEUE: begin
						if (st_q[s] == SLOT_RUNNABLE) unlink(s);
						if (st_q[s] != SLOT_INACTIVE) st_q[s] = SLOT_SLEEPING;
					end
					OP_CHARGE: begin
						if (bud_q[s] > 1) begin
							bud_q[s]--;
						end else begin
							bud_q[s] = 0;
							exp_q[s] = 1;
						end
					end
					default: begin
						if (st_q[s] == SLOT_RUNNABLE) unlink(s);
						st_q[s] = SLOT_INACTIVE;
						lvl_q[s] = 0;
						bud_q[s] = 0;
						exp_q[s] = 0;
					end
				endcase
			end
			if (report) begin
				r.lvl = lvl_q[rs];
				r.bud = bud_q[rs];
				r.exp = exp_q[rs];
			end
			pending_q.push_back(r);
		endfunction

		function void check_result(sched_result_t got);
			sched_result_t want;
			if (pending_q.size() == 0) begin
				$error("result with no request outstanding");
				errors++;
				return;
			end
			want = pending_q.pop_front();
			if (got.pv != want.pv) begin
				$error("picked_valid: expected %0d, got %0d", want.pv, got.pv); errors++;
			end
			if (got.ps != want.ps) begin
				$error("picked_slot: expected %0d, got %0d", want.ps, got.ps); errors++;
			end
			if (got.lvl != want.lvl) begin
				$error("slot_level: expected %0d, got %0d", want.lvl, got.lvl); errors++;
			end
			if (got.bud != want.bud) begin
				$error("slot_budget: expected %0d, got %0d", want.bud, got.bud); errors++;
			end
			if (got.exp != want.exp) begin
				$error("slot_expired: expected %0d, got %0d", want.exp, got.exp); errors++;
			end
			if (got.boosted != want.boosted) begin
				$error("boost_done: expected %0d, got %0d", want.boosted, got.boosted);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [19:0] cfg_data;
	logic        in_valid;
	logic        in_stall;
	logic [2:0]  opcode;
	logic [5:0]  slot;
	logic [2:0]  enqueue_reason;
	logic [31:0] now_tick;
	logic [31:0] block_tick;
	logic        out_valid;
	logic        out_stall;
	logic        picked_valid;
	logic [5:0]  picked_slot;
	logic [2:0]  slot_level;
	logic [15:0] slot_budget;
	logic        slot_expired;
	logic        boost_done;

	sched_scoreboard sb;
	// When set, neither side inserts random gaps or stalls.
	bit          steady;
	// Asks the receiver to hold off for a long stretch.
	bit          hold_go;
	bit [31:0]   tick_now;

	mlfq_scheduler_core i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.opcode(opcode), .slot(slot), .enqueue_reason(enqueue_reason),
		.now_tick(now_tick), .block_tick(block_tick),
		.out_valid(out_valid), .out_stall(out_stall),
		.picked_valid(picked_valid), .picked_slot(picked_slot),
		.slot_level(slot_level), .slot_budget(slot_budget),
		.slot_expired(slot_expired), .boost_done(boost_done)
	);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	// Hard stop in case the block hangs.
	initial begin
		#20ms;
		$display("[FAIL] regression broken");
		$finish;
	end

	// Both handshakes are observed at the rising edge, where every input was set
	// at the falling edge before it.
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall)
			sb.note_request(opcode, slot, enqueue_reason, now_tick, block_tick);
		if (arst_n && out_valid && !out_stall)
			sb.check_result('{picked_valid, picked_slot, slot_level, slot_budget,
				slot_expired, boost_done});
	end

	// Receiver: random stalls, none while steady, and a long hold-off on request.
	initial begin
		out_stall = 0;
		forever begin
			@(negedge clk);
			if (hold_go) begin
				hold_go = 0;
				for (int i = 0; i < 300; i++) begin
					out_stall = 1;
					@(negedge clk);
				end
			end
			out_stall = steady ? 1'b0 : ($urandom_range(99) < 35);
		end
	end

	// Offers one request and holds it until the block takes it.
	task automatic send_request(bit [2:0] op, bit [5:0] s, bit [2:0] reason,
			bit [31:0] now, bit [31:0] blk);
		while (!steady && $urandom_range(99) < 35) @(negedge clk);
		in_valid = 1;
		opcode = op;
		slot = s;
		enqueue_reason = reason;
		now_tick = now;
		block_tick = blk;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		in_valid = 0;
	endtask

	// Waits until every expected result has come back, then lets a boost walk finish.
	task automatic drain();
		while (sb.pending_q.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(bit [2:0] idx, bit [19:0] val);
		cfg_we = 1;
		cfg_index = idx;
		cfg_data = val;
		sb.write_reg(idx, val);
		@(negedge clk);
		cfg_we = 0;
	endtask

	task automatic set_quanta(bit [15:0] q0, bit [15:0] q1, bit [15:0] q2, bit [15:0] q3,
			bit [15:0] q4, bit [19:0] period, bit [15:0] sleep_min);
		write_reg(CFG_QUANTUM0, q0);
		write_reg(CFG_QUANTUM1, q1);
		write_reg(CFG_QUANTUM2, q2);
		write_reg(CFG_QUANTUM3, q3);
		write_reg(CFG_QUANTUM4, q4);
		write_reg(CFG_BOOST_PERIOD, period);
		write_reg(CFG_PROMOTE_SLEEP, sleep_min);
	endtask

	// One random request. Most requests address a few slots so that the level lists
	// grow long and slots travel across levels; the rest spread over the whole table.
	task automatic random_request();
		int w;
		bit [2:0] op;
		bit [5:0] s;
		bit [31:0] blk;
		w = $urandom_range(99);
		if (w < 30) op = OP_ENQUEUE;
		else if (w < 55) op = OP_CHARGE;
		else if (w < 70) op = OP_PICK;
		else if (w < 80) op = OP_DEQUEUE;
		else if (w < 88) op = OP_BOOST;
		else if (w < 95) op = OP_RETIRE;
		else op = 3'($urandom_range(7));
		s = ($urandom_range(3) != 0) ? 6'($urandom_range(7)) : 6'($urandom_range(63));
		if ($urandom_range(19) == 0)
			tick_now = $urandom;
		else
			tick_now += $urandom_range(40);
		blk = ($urandom_range(9) == 0) ? $urandom : tick_now - $urandom_range(5);
		send_request(op, s, 3'($urandom_range(7)), tick_now, blk);
	endtask

	initial begin
		sb = new();
		sb.reset_state();
		steady = 0;
		hold_go = 0;
		tick_now = 0;
		arst_n = 0;
		cfg_we = 0;
		cfg_index = CFG_QUANTUM0;
		cfg_data = 0;
		in_valid = 0;
		opcode = OP_ENQUEUE;
		slot = 0;
		enqueue_reason = RSN_YIELD;
		now_tick = 0;
		block_tick = 0;
		repeat (2) @(negedge clk);
		arst_n = 1;

		// Directed: starts, an expiring yield that demotes, wakes after short and long
		// sleeps, unknown reasons and opcodes, picks down to an empty table, boosts
		// and the extremes of every field.
		send_request(OP_PICK, 0, RSN_YIELD, 0, 0);
		send_request(OP_BOOST, 0, RSN_YIELD, 0, 0);
		send_request(OP_ENQUEUE, 0, 3'd4, 0, 0);
		send_request(OP_ENQUEUE, 63, 3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_request(OP_CHARGE, 0, RSN_YIELD, 1, 0);
		send_request(OP_CHARGE, 0, RSN_YIELD, 2, 0);
		send_request(OP_ENQUEUE, 0, RSN_YIELD, 3, 0);
		send_request(OP_ENQUEUE, 63, RSN_YIELD, 3, 0);
		send_request(OP_DEQUEUE, 0, RSN_YIELD, 4, 0);
		send_request(OP_ENQUEUE, 0, RSN_WAKE, 4, 4);
		send_request(OP_ENQUEUE, 0, 3'd2, 10, 4);
		send_request(OP_ENQUEUE, 63, RSN_SIGNAL, 0, 32'hFFFF_FFFF);
		send_request(OP_ENQUEUE, 21, 3'd5, 32'h5555_5555, 32'hAAAA_AAAA);
		send_request(3'd6, 42, RSN_YIELD, 0, 0);
		send_request(3'd7, 42, RSN_YIELD, 0, 0);
		send_request(OP_DEQUEUE, 42, RSN_YIELD, 0, 0);
		send_request(OP_BOOST, 0, RSN_YIELD, 32'hAAAA_AAAA, 0);
		send_request(OP_PICK, 0, RSN_YIELD, 0, 0);
		send_request(OP_PICK, 0, RSN_YIELD, 0, 0);
		send_request(OP_RETIRE, 63, RSN_YIELD, 0, 0);
		send_request(OP_PICK, 0, RSN_YIELD, 0, 0);
		send_request(OP_PICK, 0, RSN_YIELD, 0, 0);
		send_request(OP_RETIRE, 21, RSN_YIELD, 0, 0);

		// Random phases, each under its own register setting: quanta of one with a
		// boost period of one, the largest with rare boosts, zero quanta with boosts
		// on every check, and a mixed setting.
		for (int phase = 0; phase < 4; phase++) begin
			drain();
			case (phase)
				0: set_quanta(1, 1, 1, 1, 1, 1, 0);
				1: set_quanta(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 20'hFFFFF,
					16'hFFFF);
				2: set_quanta(0, 0, 0, 0, 0, 0, 3);
				default: set_quanta(3, 5, 2, 4, 6, 37, 2);
			endcase
			for (int n = 0; n < 150; n++) begin
				// A stretch with no gaps on either side, and in it, in the second phase only,
				// a long receiver hold-off while requests keep coming so that the block backs up.
				if (n == 40) steady = 1;
				if (n == 50 && phase == 1) hold_go = 1;
				if (n == 90) steady = 0;
				random_request();
			end
		end

		drain();
		while (sb.pending_q.size() != 0) begin
			void'(sb.pending_q.pop_front());
			$error("expected result never arrived");
			sb.errors++;
		end
		if (sb.errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

[files.f]
src/mlfq_pkg.sv
src/mlfq_attr_mem.sv
src/mlfq_link_mem.sv
src/mlfq_scheduler_core.sv
tb/sv/mlfq_scheduler_core_tb.sv
